/* hdl/sst_pkg.sv */
package sst_pkg;

   // field widths
   localparam int RHS_W   = 48;
   localparam int VEC_W   = 16;
   localparam int MS_W    = 24;
   localparam int LAM_W   = 24;
   localparam int DEG_W   = 16;

   // divider geometry: 48-bit dividend, divisor up to |den16| or Ms
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 33;

   // torque vector magnitude, beta and per-component delta widths
   localparam int T_W     = 52;
   localparam int BETA_W  = 63;
   localparam int DELTA_W = 50;

   localparam logic [BETA_W-1:0]  BETA_LIMIT  = 63'h4000_0000_0000_0000;
   localparam logic [DELTA_W-1:0] DELTA_LIMIT = 50'h2_0000_0000_0000;
   localparam logic [LAM_W+1:0]   ONE_Q16     = 26'd65536;
   localparam logic [DEG_W-1:0]   DEG_ONE     = 16'd4096;

   typedef enum logic [2:0] {
      CSR_ENABLE,
      CSR_DRIVE,
      CSR_POL_X,
      CSR_POL_Y,
      CSR_POL_Z,
      CSR_LAMBDA,
      CSR_DEGREE,
      CSR_EPSILON
   } csr_index_type;

   typedef struct packed {
      logic [VEC_W-1:0] mag_x;
      logic [VEC_W-1:0] mag_y;
      logic [VEC_W-1:0] mag_z;
      logic [MS_W-1:0]  sat_magnetization;
      logic             node_is_magnetic;
      logic [RHS_W-1:0] rhs_in_x;
      logic [RHS_W-1:0] rhs_in_y;
      logic [RHS_W-1:0] rhs_in_z;
   } req_type;

   typedef struct packed {
      logic [RHS_W-1:0] rhs_out_x;
      logic [RHS_W-1:0] rhs_out_y;
      logic [RHS_W-1:0] rhs_out_z;
      logic             saturated;
   } rsp_type;

   // per-node data that rides alongside the dividers
   typedef struct packed {
      logic                  active;
      logic                  neg_beta;
      logic [2:0]            t_neg;
      logic [2:0][T_W-1:0]   t_mag;
      logic [2:0][RHS_W-1:0] rhs;
   } side_type;

endpackage

/* hdl/sst_div.sv */
// Unsigned restoring divider, one quotient bit per pipeline stage.
module sst_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_step
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [DEN_W-1:0] den_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             fits;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign nq_prev  = nq_ff[i-1];
         assign den_prev = den_ff[i-1];
      end

      // shift in next dividend bit, subtract if it fits
      assign trial  = {rem_prev, nq_prev[NUM_W-1]};
      assign diff   = trial - {1'b0, den_prev};
      assign fits   = trial >= {1'b0, den_prev};
      assign rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign nq_in  = {nq_prev[NUM_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= rem_in;
            nq_ff[i]  <= nq_in;
            den_ff[i] <= den_prev;
         end
      end
   end

   assign quo = nq_ff[NUM_W-1];

endmodule

/* hdl/slonczewski_spin_torque.sv */
// Slonczewski spin-transfer torque: adds beta*(m x (m x p) + eps'*(m x p)) to one
// node's right-hand-side vector per beat. A node enters every cycle while the
// result side is not stalled; on its way each node passes through the two
// 48-stage restoring dividers (drive/Ms and degree*lambda*16/|den16|)
// that run side by side. Configuration writes must only happen while no node
// is in flight.
module slonczewski_spin_torque
   import sst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [RHS_W-1:0] csr_wdata
);

   // configuration registers
   logic                   enable_ff;
   logic [RHS_W-1:0]       drive_ff;
   logic [2:0][VEC_W-1:0]  pol_ff;
   logic [LAM_W-1:0]       lambda_ff;
   logic [DEG_W-1:0]       degree_ff;
   logic [VEC_W-1:0]       eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         drive_ff  <= '0;
         pol_ff[0] <= '0;
         pol_ff[1] <= '0;
         pol_ff[2] <= 16'd16384;
         lambda_ff <= 24'd65536;
         degree_ff <= DEG_ONE;
         eps_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:  enable_ff <= csr_wdata[0];
            CSR_DRIVE:   drive_ff  <= csr_wdata;
            CSR_POL_X:   pol_ff[0] <= csr_wdata[VEC_W-1:0];
            CSR_POL_Y:   pol_ff[1] <= csr_wdata[VEC_W-1:0];
            CSR_POL_Z:   pol_ff[2] <= csr_wdata[VEC_W-1:0];
            CSR_LAMBDA:  lambda_ff <= csr_wdata[LAM_W-1:0];
            CSR_DEGREE:  degree_ff <= csr_wdata[DEG_W-1:0];
            CSR_EPSILON: eps_ff    <= csr_wdata[VEC_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the output beat is held
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic signed [VEC_W-1:0] pol_s [3];
   logic signed [VEC_W-1:0] eps_s;
   assign pol_s[0] = pol_ff[0];
   assign pol_s[1] = pol_ff[1];
   assign pol_s[2] = pol_ff[2];
   assign eps_s    = eps_ff;

   // stage 1: input register
   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic signed [VEC_W-1:0] s1_m [3];
   assign s1_m[0] = s1_req_ff.mag_x;
   assign s1_m[1] = s1_req_ff.mag_y;
   assign s1_m[2] = s1_req_ff.mag_z;

   // stage 2: m.p terms and cross-product terms
   logic                    s2_valid_ff, s2_active_ff, s2_active_in;
   logic [2:0][RHS_W-1:0]   s2_rhs_ff;
   logic [MS_W-1:0]         s2_ms_ff;
   logic signed [VEC_W-1:0] s2_m_ff [3];
   logic signed [31:0]      s2_pm_ff [3], s2_pm_in [3];
   logic signed [31:0]      s2_cp_ff [6], s2_cp_in [6];

   always_comb begin
      s2_active_in = enable_ff && s1_req_ff.node_is_magnetic &&
                     (s1_req_ff.sat_magnetization != '0);
      for (int k = 0; k < 3; k++) begin
         s2_pm_in[k] = 32'(s1_m[k]) * 32'(pol_s[k]);
      end
      s2_cp_in[0] = 32'(s1_m[1]) * 32'(pol_s[2]);
      s2_cp_in[1] = 32'(s1_m[2]) * 32'(pol_s[1]);
      s2_cp_in[2] = 32'(s1_m[2]) * 32'(pol_s[0]);
      s2_cp_in[3] = 32'(s1_m[0]) * 32'(pol_s[2]);
      s2_cp_in[4] = 32'(s1_m[0]) * 32'(pol_s[1]);
      s2_cp_in[5] = 32'(s1_m[1]) * 32'(pol_s[0]);
   end

   // stage 3: m.p sum and c = m x p
   logic                    s3_valid_ff, s3_active_ff;
   logic [2:0][RHS_W-1:0]   s3_rhs_ff;
   logic [MS_W-1:0]         s3_ms_ff;
   logic signed [VEC_W-1:0] s3_m_ff [3];
   logic signed [33:0]      s3_mp_ff, s3_mp_in;
   logic signed [32:0]      s3_c_ff [3], s3_c_in [3];

   always_comb begin
      s3_mp_in = 34'(s2_pm_ff[0]) + 34'(s2_pm_ff[1]) + 34'(s2_pm_ff[2]);
      s3_c_in[0] = 33'(s2_cp_ff[0]) - 33'(s2_cp_ff[1]);
      s3_c_in[1] = 33'(s2_cp_ff[2]) - 33'(s2_cp_ff[3]);
      s3_c_in[2] = 33'(s2_cp_ff[4]) - 33'(s2_cp_ff[5]);
   end

   // stage 4: denominator in Q.44, m x c and eps'*c terms
   logic                  s4_valid_ff, s4_active_ff;
   logic [2:0][RHS_W-1:0] s4_rhs_ff;
   logic [MS_W-1:0]       s4_ms_ff;
   logic signed [60:0]    s4_den_ff, s4_den_in;
   logic signed [48:0]    s4_mc_ff [6], s4_mc_in [6];
   logic signed [48:0]    s4_ec_ff [3], s4_ec_in [3];
   logic [LAM_W+1:0]      lam_p1;
   logic signed [LAM_W+1:0] lam_m1;

   always_comb begin
      lam_p1 = {2'b00, lambda_ff} + ONE_Q16;
      lam_m1 = $signed({2'b00, lambda_ff}) - $signed(ONE_Q16);
      s4_den_in = $signed(61'({lam_p1, 28'd0})) + 61'(lam_m1) * 61'(s3_mp_ff);
      s4_mc_in[0] = 49'(s3_m_ff[1]) * 49'(s3_c_ff[2]);
      s4_mc_in[1] = 49'(s3_m_ff[2]) * 49'(s3_c_ff[1]);
      s4_mc_in[2] = 49'(s3_m_ff[2]) * 49'(s3_c_ff[0]);
      s4_mc_in[3] = 49'(s3_m_ff[0]) * 49'(s3_c_ff[2]);
      s4_mc_in[4] = 49'(s3_m_ff[0]) * 49'(s3_c_ff[1]);
      s4_mc_in[5] = 49'(s3_m_ff[1]) * 49'(s3_c_ff[0]);
      for (int k = 0; k < 3; k++) begin
         s4_ec_in[k] = 49'(eps_s) * 49'(s3_c_ff[k]);
      end
   end

   // stage 5: den16, torque vector, divider operands
   logic                    s5_valid_ff;
   side_type                s5_side_ff, s5_side_in;
   logic [DIV_NUM_W-1:0]    s5_gnum_ff, s5_gnum_in, s5_anum_ff, s5_anum_in;
   logic [DIV_DEN_W-1:0]    s5_gden_ff, s5_gden_in, s5_aden_ff;
   logic signed [32:0]      den16;
   logic signed [T_W-1:0]   t_val [3];
   logic [DEG_W-1:0]        deg_eff;
   logic [39:0]             deg_lam;

   always_comb begin
      // truncate toward zero
      den16 = 33'(s4_den_ff >>> 28) +
              {32'd0, s4_den_ff[60] && (s4_den_ff[27:0] != '0)};
      s5_gden_in = den16[32] ? DIV_DEN_W'(-den16) : DIV_DEN_W'(den16);
      t_val[0] = 52'(s4_mc_ff[0]) - 52'(s4_mc_ff[1]) + (52'(s4_ec_ff[0]) <<< 2);
      t_val[1] = 52'(s4_mc_ff[2]) - 52'(s4_mc_ff[3]) + (52'(s4_ec_ff[1]) <<< 2);
      t_val[2] = 52'(s4_mc_ff[4]) - 52'(s4_mc_ff[5]) + (52'(s4_ec_ff[2]) <<< 2);
      deg_eff  = (degree_ff == '0) ? DEG_ONE : degree_ff;
      deg_lam  = 40'(deg_eff) * 40'(lambda_ff);
      s5_gnum_in = DIV_NUM_W'({deg_lam, 4'd0});
      s5_anum_in = drive_ff[RHS_W-1] ? DIV_NUM_W'(-$signed(drive_ff)) : drive_ff;
      s5_side_in.active   = s4_active_ff && (den16 != '0);
      s5_side_in.neg_beta = den16[32] ^ drive_ff[RHS_W-1];
      for (int k = 0; k < 3; k++) begin
         s5_side_in.t_neg[k] = t_val[k][T_W-1];
         s5_side_in.t_mag[k] = t_val[k][T_W-1] ? T_W'(-t_val[k]) : T_W'(t_val[k]);
      end
      s5_side_in.rhs = s4_rhs_ff;
   end

   // front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff    <= req_data;
         s2_active_ff <= s2_active_in;
         s2_rhs_ff    <= {s1_req_ff.rhs_in_z, s1_req_ff.rhs_in_y, s1_req_ff.rhs_in_x};
         s2_ms_ff     <= s1_req_ff.sat_magnetization;
         s2_m_ff      <= s1_m;
         s2_pm_ff     <= s2_pm_in;
         s2_cp_ff     <= s2_cp_in;
         s3_active_ff <= s2_active_ff;
         s3_rhs_ff    <= s2_rhs_ff;
         s3_ms_ff     <= s2_ms_ff;
         s3_m_ff      <= s2_m_ff;
         s3_mp_ff     <= s3_mp_in;
         s3_c_ff      <= s3_c_in;
         s4_active_ff <= s3_active_ff;
         s4_rhs_ff    <= s3_rhs_ff;
         s4_ms_ff     <= s3_ms_ff;
         s4_den_ff    <= s4_den_in;
         s4_mc_ff     <= s4_mc_in;
         s4_ec_ff     <= s4_ec_in;
         s5_side_ff   <= s5_side_in;
         s5_gnum_ff   <= s5_gnum_in;
         s5_gden_ff   <= s5_gden_in;
         s5_anum_ff   <= s5_anum_in;
         s5_aden_ff   <= DIV_DEN_W'(s4_ms_ff);
      end
   end

   // dividers: g = degree*L*16 / |den16|, a = |drive| / Ms
   logic [DIV_NUM_W-1:0] g_quo, a_quo;

   sst_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_g (
      .clock (clock),
      .adv   (adv),
      .num   (s5_gnum_ff),
      .den   (s5_gden_ff),
      .quo   (g_quo)
   );

   sst_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_a (
      .clock (clock),
      .adv   (adv),
      .num   (s5_anum_ff),
      .den   (s5_aden_ff),
      .quo   (a_quo)
   );

   // side data delay line matching divider latency
   logic     dly_valid_ff [DIV_NUM_W];
   side_type dly_side_ff  [DIV_NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_NUM_W; i++) begin
            dly_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         dly_valid_ff[0] <= s5_valid_ff;
         for (int i = 1; i < DIV_NUM_W; i++) begin
            dly_valid_ff[i] <= dly_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_side_ff[0] <= s5_side_ff;
         for (int i = 1; i < DIV_NUM_W; i++) begin
            dly_side_ff[i] <= dly_side_ff[i-1];
         end
      end
   end

   // stage 6: a*g partial products
   logic        s6_valid_ff;
   side_type    s6_side_ff;
   logic [46:0] s6_pp_ff [4], s6_pp_in [4];

   always_comb begin
      s6_pp_in[0] = 47'(a_quo[23:0])  * 47'(g_quo[22:0]);
      s6_pp_in[1] = 47'(a_quo[23:0])  * 47'(g_quo[45:23]);
      s6_pp_in[2] = 47'(a_quo[47:24]) * 47'(g_quo[22:0]);
      s6_pp_in[3] = 47'(a_quo[47:24]) * 47'(g_quo[45:23]);
   end

   // stage 7: beta magnitude = (a*g) >> 16, clamped
   logic              s7_valid_ff;
   side_type          s7_side_ff;
   logic [BETA_W-1:0] s7_beta_ff, s7_beta_in;
   logic [93:0]       ag_sum;

   always_comb begin
      ag_sum = 94'(s6_pp_ff[0]) + (94'(s6_pp_ff[1]) << 23) +
               (94'(s6_pp_ff[2]) << 24) + (94'(s6_pp_ff[3]) << 47);
      s7_beta_in = (ag_sum[93:16] > 78'(BETA_LIMIT)) ? BETA_LIMIT : ag_sum[78:16];
   end

   // stage 8: beta*|t| partial products per component
   logic        s8_valid_ff;
   side_type    s8_side_ff;
   logic [57:0] s8_pd_ff [3][4], s8_pd_in [3][4];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s8_pd_in[k][0] = 58'(s7_beta_ff[31:0])  * 58'(s7_side_ff.t_mag[k][25:0]);
         s8_pd_in[k][1] = 58'(s7_beta_ff[31:0])  * 58'(s7_side_ff.t_mag[k][51:26]);
         s8_pd_in[k][2] = 58'(s7_beta_ff[62:32]) * 58'(s7_side_ff.t_mag[k][25:0]);
         s8_pd_in[k][3] = 58'(s7_beta_ff[62:32]) * 58'(s7_side_ff.t_mag[k][51:26]);
      end
   end

   // stage 9: delta = (beta*t) >> 42, clamped, signed
   logic                   s9_valid_ff;
   side_type               s9_side_ff;
   logic signed [DELTA_W:0] s9_d_ff [3], s9_d_in [3];
   logic [115:0]           bt_sum [3];
   logic [DELTA_W-1:0]     d_mag [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bt_sum[k] = 116'(s8_pd_ff[k][0]) + (116'(s8_pd_ff[k][1]) << 26) +
                     (116'(s8_pd_ff[k][2]) << 32) + (116'(s8_pd_ff[k][3]) << 58);
         d_mag[k] = (bt_sum[k][115:42] > 74'(DELTA_LIMIT)) ? DELTA_LIMIT
                                                          : bt_sum[k][91:42];
         s9_d_in[k] = (s8_side_ff.neg_beta ^ s8_side_ff.t_neg[k])
                      ? -$signed({1'b0, d_mag[k]}) : $signed({1'b0, d_mag[k]});
      end
   end

   // stage 10: saturating add into the output register
   localparam logic signed [51:0] SUM_HI = 52'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [51:0] SUM_LO = 52'shF_8000_0000_0000;

   rsp_type               rsp_in;
   logic signed [51:0]    sum_v [3];
   logic [2:0][RHS_W-1:0] out_v;
   logic [2:0]            clip;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_v[k] = 52'($signed(s9_side_ff.rhs[k])) + 52'(s9_d_ff[k]);
         clip[k]  = 1'b0;
         if (!s9_side_ff.active) begin
            out_v[k] = s9_side_ff.rhs[k];
         end else if (sum_v[k] > SUM_HI) begin
            out_v[k] = SUM_HI[RHS_W-1:0];
            clip[k]  = 1'b1;
         end else if (sum_v[k] < SUM_LO) begin
            out_v[k] = SUM_LO[RHS_W-1:0];
            clip[k]  = 1'b1;
         end else begin
            out_v[k] = sum_v[k][RHS_W-1:0];
         end
      end
      rsp_in.rhs_out_x = out_v[0];
      rsp_in.rhs_out_y = out_v[1];
      rsp_in.rhs_out_z = out_v[2];
      rsp_in.saturated = |clip;
   end

   // back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff  <= dly_valid_ff[DIV_NUM_W-1];
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         rsp_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_side_ff <= dly_side_ff[DIV_NUM_W-1];
         s6_pp_ff   <= s6_pp_in;
         s7_side_ff <= s6_side_ff;
         s7_beta_ff <= s7_beta_in;
         s8_side_ff <= s7_side_ff;
         s8_pd_ff   <= s8_pd_in;
         s9_side_ff <= s8_side_ff;
         s9_d_ff    <= s9_d_in;
         rsp_ff     <= rsp_in;
      end
   end

`ifndef SYNTH
   // beta never exceeds its clamp
   a_beta_bound: assert property (@(posedge clock) disable iff (reset)
      s7_valid_ff |-> s7_beta_ff <= BETA_LIMIT)
      else $error("beta above clamp");

   // each delta stays within +-2^49
   a_delta_bound: assert property (@(posedge clock) disable iff (reset)
      s9_valid_ff |-> (s9_d_ff[0] <= $signed({1'b0, DELTA_LIMIT}) &&
                       s9_d_ff[0] >= -$signed({1'b0, DELTA_LIMIT}) &&
                       s9_d_ff[1] <= $signed({1'b0, DELTA_LIMIT}) &&
                       s9_d_ff[1] >= -$signed({1'b0, DELTA_LIMIT}) &&
                       s9_d_ff[2] <= $signed({1'b0, DELTA_LIMIT}) &&
                       s9_d_ff[2] >= -$signed({1'b0, DELTA_LIMIT})))
      else $error("delta above clamp");

   // a held output freezes the inner pipeline
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         ($stable(s9_valid_ff) && $stable(dly_valid_ff[DIV_NUM_W-1]) &&
          $stable(s5_valid_ff)))
      else $error("pipeline moved while output held");
`endif

endmodule

/* test/tb_top.sv */
module tb_top;
   import sst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 70;

   typedef struct {
      req_type node;
      bit      typed;
      rsp_type rhs_exp;
   } node_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [2:0]       csr_index = '0;
   logic [RHS_W-1:0] csr_wdata = '0;

   // shadow copy of the torque registers
   bit               sh_enable;
   logic [47:0]      sh_drive;
   logic [15:0]      sh_pol_x, sh_pol_y, sh_pol_z;
   logic [23:0]      sh_lambda;
   logic [15:0]      sh_degree, sh_epsilon;

   rsp_type          rhs_expected[$];
   int               errors = 0;
   int               quiet_cycles = 0;
   bit               no_idle = 1'b0;
   bit               hold_rsp = 1'b0;
   node_row_type     node_table[$];

   slonczewski_spin_torque dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // (x*y) >> sh on magnitudes, clamped to lim, sign restored
   function automatic longint mul_clamp(longint x, longint y, int sh, longint lim);
      logic [127:0] prod;
      logic [63:0]  ux, uy, mag;
      bit           neg;
      neg  = (x < 0) != (y < 0);
      ux   = (x < 0) ? -x : x;
      uy   = (y < 0) ? -y : y;
      prod = {64'd0, ux} * {64'd0, uy};
      prod = prod >> sh;
      mag  = (prod > {64'd0, lim}) ? lim : prod[63:0];
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // expected right-hand side after adding the spin torque
   function automatic rsp_type torque_update(req_type r);
      longint  m[3], p[3], rhs[3], c[3], t[3];
      longint  lam, mp, den44, den16, deg, eps, g, a, beta, d, s;
      bit      on, sat;
      rsp_type o;
      m[0] = longint'($signed(r.mag_x));
      m[1] = longint'($signed(r.mag_y));
      m[2] = longint'($signed(r.mag_z));
      rhs[0] = longint'($signed(r.rhs_in_x));
      rhs[1] = longint'($signed(r.rhs_in_y));
      rhs[2] = longint'($signed(r.rhs_in_z));
      p[0] = longint'($signed(sh_pol_x));
      p[1] = longint'($signed(sh_pol_y));
      p[2] = longint'($signed(sh_pol_z));
      lam = longint'(sh_lambda);
      sat = 1'b0;
      den16 = 0;
      on = sh_enable && r.node_is_magnetic && (r.sat_magnetization != 0);
      if (on) begin
         mp = m[0] * p[0] + m[1] * p[1] + m[2] * p[2];
         den44 = (lam + 65536) * (longint'(1) << 28) + (lam - 65536) * mp;
         den16 = den44 / (longint'(1) << 28);
         if (den16 == 0) on = 1'b0;
      end
      if (on) begin
         deg  = (sh_degree == 0) ? 4096 : longint'(sh_degree);
         eps  = longint'($signed(sh_epsilon));
         g    = (deg * lam * 16) / den16;
         a    = longint'($signed(sh_drive)) / longint'(r.sat_magnetization);
         beta = mul_clamp(a, g, 16, longint'(1) << 62);
         c[0] = m[1] * p[2] - m[2] * p[1];
         c[1] = m[2] * p[0] - m[0] * p[2];
         c[2] = m[0] * p[1] - m[1] * p[0];
         t[0] = m[1] * c[2] - m[2] * c[1] + eps * c[0] * 4;
         t[1] = m[2] * c[0] - m[0] * c[2] + eps * c[1] * 4;
         t[2] = m[0] * c[1] - m[1] * c[0] + eps * c[2] * 4;
         for (int k = 0; k < 3; k++) begin
            d = mul_clamp(beta, t[k], 42, longint'(1) << 49);
            s = rhs[k] + d;
            if (s > (longint'(1) << 47) - 1) begin
               s = (longint'(1) << 47) - 1;
               sat = 1'b1;
            end
            if (s < -(longint'(1) << 47)) begin
               s = -(longint'(1) << 47);
               sat = 1'b1;
            end
            rhs[k] = s;
         end
      end
      o.rhs_out_x = rhs[0][47:0];
      o.rhs_out_y = rhs[1][47:0];
      o.rhs_out_z = rhs[2][47:0];
      o.saturated = sat;
      return o;
   endfunction

   function automatic req_type make_node(int mx, int my, int mz, int ms, bit mag,
                                         longint rx, longint ry, longint rz);
      req_type r;
      r.mag_x = mx[15:0];
      r.mag_y = my[15:0];
      r.mag_z = mz[15:0];
      r.sat_magnetization = ms[23:0];
      r.node_is_magnetic = mag;
      r.rhs_in_x = rx[47:0];
      r.rhs_in_y = ry[47:0];
      r.rhs_in_z = rz[47:0];
      return r;
   endfunction

   // row whose result is the unchanged right-hand side
   function automatic node_row_type pass_row(req_type r);
      node_row_type row;
      row.node = r;
      row.typed = 1'b1;
      row.rhs_exp = {r.rhs_in_x, r.rhs_in_y, r.rhs_in_z, 1'b0};
      return row;
   endfunction

   function automatic node_row_type calc_row(req_type r);
      node_row_type row;
      row.node = r;
      row.typed = 1'b0;
      row.rhs_exp = '0;
      return row;
   endfunction

   function automatic logic [15:0] rand_vec();
      if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   function automatic logic [47:0] rand_wide();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return 48'h7FFF_FFFF_FFFF - $urandom_range(0, 1000);
         1: return 48'h8000_0000_0000 + $urandom_range(0, 1000);
         2: return v[47:0] >> $urandom_range(0, 47);
         default: return v[47:0];
      endcase
   endfunction

   function automatic req_type rand_node();
      req_type r;
      r.mag_x = rand_vec();
      r.mag_y = rand_vec();
      r.mag_z = rand_vec();
      case ($urandom_range(0, 9))
         0: r.sat_magnetization = 24'($urandom_range(0, 3));
         1: r.sat_magnetization = 24'hFFFFFF;
         2: r.sat_magnetization = 24'($urandom_range(1, 255));
         default: r.sat_magnetization = 24'($urandom_range(0, 24'hFFFFFF));
      endcase
      r.node_is_magnetic = ($urandom_range(0, 9) != 0);
      r.rhs_in_x = rand_wide();
      r.rhs_in_y = rand_wide();
      r.rhs_in_z = rand_wide();
      return r;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [47:0] value);
      case (idx)
         CSR_ENABLE:  sh_enable  = value[0];
         CSR_DRIVE:   sh_drive   = value;
         CSR_POL_X:   sh_pol_x   = value[15:0];
         CSR_POL_Y:   sh_pol_y   = value[15:0];
         CSR_POL_Z:   sh_pol_z   = value[15:0];
         CSR_LAMBDA:  sh_lambda  = value[23:0];
         CSR_DEGREE:  sh_degree  = value[15:0];
         CSR_EPSILON: sh_epsilon = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // block must be empty before registers change; stop offering the last beat
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (rhs_expected.size() == 0);
      @(posedge clock);
   endtask

   task automatic write_all(bit en, logic [47:0] drv, logic [15:0] px, logic [15:0] py,
                            logic [15:0] pz, logic [23:0] lam, logic [15:0] deg,
                            logic [15:0] eps);
      wait_drained();
      write_reg(CSR_ENABLE, {47'd0, en});
      write_reg(CSR_DRIVE, drv);
      write_reg(CSR_POL_X, {32'd0, px});
      write_reg(CSR_POL_Y, {32'd0, py});
      write_reg(CSR_POL_Z, {32'd0, pz});
      write_reg(CSR_LAMBDA, {24'd0, lam});
      write_reg(CSR_DEGREE, {32'd0, deg});
      write_reg(CSR_EPSILON, {32'd0, eps});
   endtask

   task automatic write_random_setting();
      logic [47:0] drv;
      logic [23:0] lam;
      logic [15:0] deg, eps;
      case ($urandom_range(0, 4))
         0: drv = 48'h7FFF_FFFF_FFFF;
         1: drv = 48'h8000_0000_0000;
         default: drv = rand_wide();
      endcase
      case ($urandom_range(0, 4))
         0: lam = 24'hFFFFFF;
         1: lam = 24'd0;
         default: lam = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
      endcase
      case ($urandom_range(0, 4))
         0: deg = 16'd0;
         1: deg = 16'hFFFF;
         default: deg = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 4))
         0: eps = 16'h7FFF;
         1: eps = 16'h8000;
         default: eps = 16'($urandom_range(0, 65535));
      endcase
      write_all($urandom_range(0, 7) != 0, drv, rand_vec(), rand_vec(), rand_vec(),
                lam, deg, eps);
   endtask

   // offer one node beat; expectation is queued when it is accepted
   task automatic send_node(req_type r, bit typed, rsp_type typed_exp);
      int gap;
      rsp_type e;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      e = typed ? typed_exp : torque_update(r);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      rhs_expected.push_back(e);
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // result side: random stall before each beat unless no_idle, one long hold on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!no_idle) begin
            n = $urandom_range(0, 19);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rhs_expected.size() == 0) begin
            report("unexpected beat", 0, 0);
         end else begin
            e = rhs_expected.pop_front();
            if (rsp_data.rhs_out_x !== e.rhs_out_x)
               report("rhs_out_x", longint'(rsp_data.rhs_out_x), longint'(e.rhs_out_x));
            if (rsp_data.rhs_out_y !== e.rhs_out_y)
               report("rhs_out_y", longint'(rsp_data.rhs_out_y), longint'(e.rhs_out_y));
            if (rsp_data.rhs_out_z !== e.rhs_out_z)
               report("rhs_out_z", longint'(rsp_data.rhs_out_z), longint'(e.rhs_out_z));
            if (rsp_data.saturated !== e.saturated)
               report("saturated", longint'(rsp_data.saturated), longint'(e.saturated));
         end
      end
   end

   // watchdog on cycles without any accepted beat or register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      sh_enable = 1'b0;
      sh_drive = '0;
      sh_pol_x = '0;
      sh_pol_y = '0;
      sh_pol_z = 16'd16384;
      sh_lambda = 24'd65536;
      sh_degree = 16'd4096;
      sh_epsilon = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset the torque is off: plain pass-through
      node_table.push_back(pass_row(make_node(0, 0, 16384, 1000, 1, 0, 0, 0)));
      node_table.push_back(pass_row(make_node(16384, -16384, 0, 24'hFFFFFF, 1,
         48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h1234_5678_9ABC)));
      node_table.push_back(pass_row(make_node(-32768, 32767, -1, 1, 1,
         -1, 1, 48'h8000_0000_0000)));
      foreach (node_table[i])
         send_node(node_table[i].node, node_table[i].typed, node_table[i].rhs_exp);
      node_table.delete();

      // torque on, tilted polarization
      write_all(1'b1, 48'h0000_1000_0000, 16'd11585, 16'd0, 16'd11585, 24'd131072,
                16'd4096, 16'd2048);
      node_table.push_back(pass_row(make_node(16384, 0, 0, 800, 0, 5, 6, 7)));
      node_table.push_back(pass_row(make_node(16384, 0, 0, 0, 1, 5, 6, 7)));
      node_table.push_back(calc_row(make_node(16384, 0, 0, 800, 1, 0, 0, 0)));
      node_table.push_back(calc_row(make_node(0, 16384, 0, 1, 1, 0, 0, 0)));
      node_table.push_back(calc_row(make_node(0, 0, -16384, 24'hFFFFFF, 1, 0, 0, 0)));
      node_table.push_back(calc_row(make_node(-32768, -32768, -32768, 1, 1,
         48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 0)));
      node_table.push_back(calc_row(make_node(32767, 32767, 32767, 1, 1,
         48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF)));
      node_table.push_back(calc_row(make_node(9000, -9000, 9000, 3, 1, 1, -1, 0)));
      foreach (node_table[i])
         send_node(node_table[i].node, node_table[i].typed, node_table[i].rhs_exp);
      node_table.delete();

      // lambda zero with m parallel to p: denominator vanishes
      write_all(1'b1, 48'h7FFF_FFFF_FFFF, 16'd0, 16'd0, 16'd16384, 24'd0, 16'd0,
                16'h8000);
      node_table.push_back(pass_row(make_node(0, 0, 16384, 1, 1, 11, 22, 33)));
      node_table.push_back(calc_row(make_node(16384, 0, 0, 1, 1, 0, 0, 0)));
      node_table.push_back(calc_row(make_node(-16384, 0, 0, 2, 1, -5, 5, 0)));
      foreach (node_table[i])
         send_node(node_table[i].node, node_table[i].typed, node_table[i].rhs_exp);
      node_table.delete();

      // extreme drive and lambda, largest degree, most positive epsilon
      write_all(1'b1, 48'h8000_0000_0000, 16'h8000, 16'h7FFF, 16'd16384, 24'hFFFFFF,
                16'hFFFF, 16'h7FFF);
      send_node(make_node(0, 16384, 0, 1, 1, 0, 0, 0), 1'b0, none);
      send_node(make_node(16384, 16384, -16384, 7, 1, 48'h7FFF_FFFF_FFFF,
         48'h8000_0000_0000, 0), 1'b0, none);
      send_node(make_node(-16384, 0, 16384, 24'hFFFFFF, 1, 1, 2, 3), 1'b0, none);

      // random phases; one with a long receiver hold and no sender gaps
      for (int ph = 0; ph < 10; ph++) begin
         write_random_setting();
         no_idle = (ph == 3) || (ph == 7);
         if (ph == 5) begin
            no_idle = 1'b1;
            hold_rsp = 1'b1;
         end
         repeat (143) send_node(rand_node(), 1'b0, none);
         no_idle = 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait (rhs_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
hdl/sst_pkg.sv
hdl/sst_div.sv
hdl/slonczewski_spin_torque.sv
test/tb_top.sv
